### hdl/lcpf_pkg.sv
// ----------------------------------------------------------------------------
// Length/CRC packet framer package
// Shared types, byte constants and the CRC-16 byte fold.
// ----------------------------------------------------------------------------
package lcpf_pkg;

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] ShortLimit = 16'd255;
  localparam logic [7:0]  StartShort = 8'h02;
  localparam logic [7:0]  StartLong  = 8'h03;
  localparam logic [7:0]  StopByte   = 8'h03;

  localparam int unsigned QueueDepthDefault = 4;

  // One accepted payload word after classification by the front end.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic        first;
    logic        is_long;
    logic        last;
    logic [15:0] crc;
  } lcpf_entry_t;

  // Emission phase of the back end.
  typedef enum logic [2:0] {
    PH_BEGIN,
    PH_START,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_STOP
  } lcpf_phase_e;

  // Fold one byte into a CRC-16, MSB first.
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/lcpf_front.sv
// ----------------------------------------------------------------------------
// Framer front end
// Accepts payload words, tracks frame position and the running CRC.
// ----------------------------------------------------------------------------
module lcpf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic [15:0]          payload_length_i,
  input  logic                 last_byte_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output lcpf_pkg::lcpf_entry_t entry_o
);

  logic        inside_q, inside_d;
  logic [15:0] crc_q, crc_d;
  logic        first, is_long, last_eff;
  logic [15:0] crc_next;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    first    = !inside_q;
    is_long  = first && (payload_length_i > lcpf_pkg::ShortLimit);
    // A long header cannot close on its first byte.
    last_eff = last_byte_i && !is_long;
    crc_next = lcpf_pkg::crc_fold(first ? 16'h0000 : crc_q, data_byte_i);

    entry_o.data    = data_byte_i;
    entry_o.len     = payload_length_i;
    entry_o.first   = first;
    entry_o.is_long = is_long;
    entry_o.last    = last_eff;
    entry_o.crc     = crc_next;

    inside_d = inside_q;
    crc_d    = crc_q;
    if (push_o) begin
      inside_d = !last_eff;
      crc_d    = last_eff ? 16'h0000 : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      crc_q    <= 16'h0000;
    end else begin
      inside_q <= inside_d;
      crc_q    <= crc_d;
    end
  end

endmodule

### hdl/lcpf_queue.sv
// ----------------------------------------------------------------------------
// Framer word queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lcpf_queue #(
  parameter int unsigned Depth = lcpf_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lcpf_pkg::lcpf_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output lcpf_pkg::lcpf_entry_t head_o,
  output logic                  valid_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcpf_pkg::lcpf_entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

### hdl/lcpf_back.sv
// ----------------------------------------------------------------------------
// Framer back end
// Expands queued words into the header, payload and trailer bytes of each frame.
// ----------------------------------------------------------------------------
module lcpf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcpf_pkg::lcpf_entry_t head_i,
  input  logic                  q_valid_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  frame_end_o
);

  lcpf_pkg::lcpf_phase_e phase_q, phase_d, cur, nxt;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       frame_end_q, frame_end_d;
  logic       can_load, advance, done;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

  always_comb begin
    can_load = !out_valid_q || !out_stall_i;
    advance  = can_load && q_valid_i;

    // The head entry is only looked at when the queue holds a word.
    cur = phase_q;
    if (phase_q == lcpf_pkg::PH_BEGIN && q_valid_i) begin
      cur = head_i.first ? lcpf_pkg::PH_START : lcpf_pkg::PH_DATA;
    end

    out_byte_d  = out_byte_q;
    frame_end_d = 1'b0;
    nxt         = lcpf_pkg::PH_BEGIN;
    done        = 1'b0;
    unique case (cur)
      lcpf_pkg::PH_BEGIN,
      lcpf_pkg::PH_DATA: begin
        out_byte_d = head_i.data;
        nxt        = lcpf_pkg::PH_CRC_HI;
        done       = !head_i.last;
      end
      lcpf_pkg::PH_START: begin
        out_byte_d = head_i.is_long ? lcpf_pkg::StartLong : lcpf_pkg::StartShort;
        nxt        = head_i.is_long ? lcpf_pkg::PH_LEN_HI : lcpf_pkg::PH_LEN_LO;
      end
      lcpf_pkg::PH_LEN_HI: begin
        out_byte_d = head_i.len[15:8];
        nxt        = lcpf_pkg::PH_LEN_LO;
      end
      lcpf_pkg::PH_LEN_LO: begin
        out_byte_d = head_i.len[7:0];
        nxt        = lcpf_pkg::PH_DATA;
      end
      lcpf_pkg::PH_CRC_HI: begin
        out_byte_d = head_i.crc[15:8];
        nxt        = lcpf_pkg::PH_CRC_LO;
      end
      lcpf_pkg::PH_CRC_LO: begin
        out_byte_d = head_i.crc[7:0];
        nxt        = lcpf_pkg::PH_STOP;
      end
      lcpf_pkg::PH_STOP: begin
        out_byte_d  = lcpf_pkg::StopByte;
        frame_end_d = 1'b1;
        done        = 1'b1;
      end
    endcase

    pop_o       = advance && done;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      phase_d     = done ? lcpf_pkg::PH_BEGIN : nxt;
      out_valid_d = 1'b1;
    end else if (can_load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lcpf_pkg::PH_BEGIN;
      out_valid_q <= 1'b0;
      frame_end_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        frame_end_q <= frame_end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= out_byte_d;
    end
  end

endmodule

### hdl/length_crc_packet_framer.sv
// A word's first byte appears after the queue and the back end's single output
// register, which sets the throughput: one payload byte per cycle within a frame
// while not stalled; a frame's first word follows a start byte and one (short) or
// two (long) length bytes, and its last word precedes two CRC bytes and a stop byte.
// Reset (rst_ni low, asynchronous) empties the queue, clears the CRC and frame state.
// ----------------------------------------------------------------------------
// Length-prefixed packet framer with CRC-16 trailer
// Frames a stream of payload words with a length header, a CRC-16
// (poly 0x1021, init 0) and a stop byte.
// ----------------------------------------------------------------------------
module length_crc_packet_framer #(
  parameter int unsigned QueueDepth = lcpf_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] payload_length_i,
  input  logic        last_byte_i,
  // Output words.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  // The front end classifies each word (first of frame, long header, last) and
  // folds its byte into the running CRC, so every queued word carries the CRC
  // value that its trailer would need.
  lcpf_pkg::lcpf_entry_t push_entry, head;
  logic push, q_full, q_valid, pop;

  lcpf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .payload_length_i(payload_length_i),
    .last_byte_i     (last_byte_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  // The queue lets the front keep taking words while the back end spends
  // extra cycles on header and trailer bytes.
  lcpf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (q_valid)
  );

  // The back end walks each word through its header, payload and trailer
  // bytes and drives the registered output; a word leaves the queue when its
  // final byte is loaded.
  lcpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_valid_i  (q_valid),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .frame_end_o(frame_end_o)
  );

endmodule
